[rtl/core/cur_pkg.sv]
// Shared types and codes for the chunked update reassembly block.
// No dependencies; imported by the top level, the checker and the testbench.
package cur_pkg;

    // Item kinds
    localparam logic [1:0] KIND_ANNOUNCE = 2'd0;
    localparam logic [1:0] KIND_CHUNK    = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    // Result status codes
    localparam logic [3:0] ST_IGNORED   = 4'd0;
    localparam logic [3:0] ST_INVALID   = 4'd1;
    localparam logic [3:0] ST_CURRENT   = 4'd2;
    localparam logic [3:0] ST_NOT_NEWER = 4'd3;
    localparam logic [3:0] ST_REFRESHED = 4'd4;
    localparam logic [3:0] ST_STARTED   = 4'd5;
    localparam logic [3:0] ST_STORED    = 4'd6;
    localparam logic [3:0] ST_DUPLICATE = 4'd7;
    localparam logic [3:0] ST_TIMEOUT   = 4'd8;
    localparam logic [3:0] ST_COMPLETED = 4'd9;

    // Error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_INST_VERSION = 3'd0;
    localparam logic [2:0] CFG_INST_CRC     = 3'd1;
    localparam logic [2:0] CFG_INST_COUNT   = 3'd2;
    localparam logic [2:0] CFG_REC_CAPACITY = 3'd3;
    localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd4;

    // Epoch mark kept per chunk entry in the seen memory
    localparam int unsigned EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_CALC,
        SEQ_DECIDE
    } seq_state_t;

endpackage

[rtl/core/cur_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cur_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/chunked_update_reassembly.sv]
// Top level of the chunked update reassembly tracker.
// Depends on cur_pkg and cur_ram (chunk seen memory with epoch marks).
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | kind, mac, flags, announce/chunk header
//  m_      | out       | m_valid / m_ready   | status, reply, record write, done, counters
//  cfg_    | in        | cfg_wr_en           | cfg_index, cfg_data (32 bits)
//
// Each word passes through capture, multiply (chunk count check or record
// offset, one shared multiplier) while the seen memory is read, then decide and
// write back. A new word is taken only after the previous one has been decided.
// After reset, and after every 255th staging start, a clearing pass sweeps all
// RECORD_CAPACITY entries of the seen memory; no word is taken meanwhile.
// A stalled result holds the decide step until m_ready.
module chunked_update_reassembly #(
    parameter int unsigned RECORD_CAPACITY = 1024,
    parameter int unsigned MAX_PER_CHUNK   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [47:0] s_sender_mac,
    input  logic        s_is_broadcast,
    input  logic        s_force_flag,
    input  logic [31:0] s_update_version,
    input  logic [31:0] s_update_crc,
    input  logic [15:0] s_record_total,
    input  logic [7:0]  s_records_each_chunk,
    input  logic [15:0] s_chunk_total,
    input  logic [15:0] s_chunk_number,
    input  logic [7:0]  s_chunk_records,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic        m_reply_needed,
    output logic [47:0] m_reply_mac,
    output logic        m_write_enable,
    output logic [9:0]  m_write_offset,
    output logic [7:0]  m_write_count,
    output logic        m_done_res,
    output logic [31:0] m_done_version,
    output logic [31:0] m_done_crc,
    output logic [10:0] m_done_count,
    output logic [10:0] m_received_chunks,
    output logic [1:0]  m_last_error
);

    import cur_pkg::*;

    localparam int unsigned AW = (RECORD_CAPACITY > 1) ? $clog2(RECORD_CAPACITY) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(RECORD_CAPACITY - 1);

    // Configuration registers
    logic [31:0] inst_version_reg;
    logic [31:0] inst_crc_reg;
    logic [10:0] inst_count_reg;
    logic [10:0] rec_capacity_reg;
    logic [31:0] idle_timeout_reg;

    // Staging state
    logic        stg_active_reg, stg_active_next;
    logic [31:0] stg_version_reg, stg_version_next;
    logic [31:0] stg_crc_reg, stg_crc_next;
    logic [10:0] stg_count_reg, stg_count_next;
    logic [7:0]  stg_per_reg, stg_per_next;
    logic [10:0] stg_ctot_reg, stg_ctot_next;
    logic [10:0] rcvd_reg, rcvd_next;
    logic [31:0] idle_reg, idle_next;
    logic [47:0] ann_mac_reg, ann_mac_next;
    logic [1:0]  err_reg, err_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;

    // Sequencer
    seq_state_t  state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic        epoch_wrap;

    // Captured word
    logic [1:0]  in_kind_reg;
    logic [47:0] in_mac_reg;
    logic        in_force_reg;
    logic [31:0] in_ver_reg;
    logic [31:0] in_crc_reg;
    logic [15:0] in_total_reg;
    logic [7:0]  in_per_reg;
    logic [15:0] in_ctot_reg;
    logic [15:0] in_cnum_reg;
    logic [7:0]  in_crec_reg;
    logic [23:0] prod_reg;

    // Result register
    logic        m_valid_reg;
    logic [3:0]  o_status_reg, o_status;
    logic        o_reply_reg, o_reply;
    logic [47:0] o_reply_mac_reg, o_reply_mac;
    logic        o_wen_reg, o_wen;
    logic [9:0]  o_woff_reg, o_woff;
    logic [7:0]  o_wcnt_reg, o_wcnt;
    logic        o_done_reg, o_done;
    logic [31:0] o_dver_reg, o_dver;
    logic [31:0] o_dcrc_reg, o_dcrc;
    logic [10:0] o_dcnt_reg, o_dcnt;
    logic [10:0] o_rcvd_reg;
    logic [1:0]  o_err_reg;

    // Memory ports
    logic               ram_wr_en, dec_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [EPOCH_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [EPOCH_W-1:0] ram_rd_data;

    logic accept, decide_go;

    assign accept    = s_valid && s_ready;
    assign decide_go = (state_reg == SEQ_DECIDE) && (!m_valid_reg || m_ready);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inst_version_reg <= '0;
            inst_crc_reg     <= '0;
            inst_count_reg   <= '0;
            rec_capacity_reg <= 11'd1024;
            idle_timeout_reg <= 32'd10000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_INST_VERSION: inst_version_reg <= cfg_data;
                CFG_INST_CRC:     inst_crc_reg     <= cfg_data;
                CFG_INST_COUNT:   inst_count_reg   <= cfg_data[10:0];
                CFG_REC_CAPACITY: rec_capacity_reg <= cfg_data[10:0];
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_CLEAR:  if (clr_reg == CLR_LAST) state_next = SEQ_IDLE;
            SEQ_IDLE:   if (accept) state_next = SEQ_CALC;
            SEQ_CALC:   state_next = SEQ_DECIDE;
            SEQ_DECIDE: if (decide_go) state_next = epoch_wrap ? SEQ_CLEAR : SEQ_IDLE;
            default:    state_next = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready     = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = in_cnum_reg[AW-1:0];
        ram_wr_data = epoch_reg;
        unique case (state_reg)
            SEQ_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
            end
            SEQ_IDLE: begin
                s_ready   = 1'b1;
                ram_rd_en = s_valid;
            end
            SEQ_DECIDE: begin
                ram_wr_en = dec_wr_en && decide_go;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == SEQ_CLEAR) begin
                clr_reg <= (clr_reg == CLR_LAST) ? '0 : clr_reg + AW'(1);
            end
        end
    end

    cur_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (RECORD_CAPACITY)
    ) u_seen_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (s_chunk_number[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Capture the word
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_kind_reg  <= s_kind;
            in_mac_reg   <= s_sender_mac;
            in_force_reg <= s_force_flag && !s_is_broadcast;
            in_ver_reg   <= s_update_version;
            in_crc_reg   <= s_update_crc;
            in_total_reg <= s_record_total;
            in_per_reg   <= s_records_each_chunk;
            in_ctot_reg  <= s_chunk_total;
            in_cnum_reg  <= s_chunk_number;
            in_crec_reg  <= s_chunk_records;
        end
    end

    // Shared multiplier: chunk count bound for announces, record offset for chunks
    always_ff @(posedge aclk) begin
        if (state_reg == SEQ_CALC) begin
            if (in_kind_reg == KIND_ANNOUNCE) begin
                prod_reg <= 24'(in_ctot_reg) * 24'(in_per_reg);
            end else begin
                prod_reg <= 24'(in_cnum_reg) * 24'(stg_per_reg);
            end
        end
    end

    // Decide step
    logic        force_a, valid_a, ctot_ok, same_inst, newer, same_stg, older;
    logic        chunk_ok, seen;
    logic [23:0] total24, remain;
    logic [7:0]  expect_rec;
    logic [31:0] idle_inc;

    always_comb begin
        force_a   = in_force_reg;
        total24   = 24'(in_total_reg);
        ctot_ok   = (in_total_reg == 16'd0) ? (in_ctot_reg == 16'd0)
                  : ((in_ctot_reg != 16'd0) && (prod_reg >= total24) &&
                     ((prod_reg - 24'(in_per_reg)) < total24));
        valid_a   = (in_per_reg != 8'd0) && (32'(in_per_reg) <= MAX_PER_CHUNK) &&
                    (in_total_reg <= 16'(rec_capacity_reg)) &&
                    (32'(in_total_reg) <= RECORD_CAPACITY) && ctot_ok;
        same_inst = (in_ver_reg == inst_version_reg) && (in_crc_reg == inst_crc_reg) &&
                    (in_total_reg == 16'(inst_count_reg));
        newer     = (in_ver_reg > inst_version_reg) || force_a;
        same_stg  = stg_active_reg && (stg_version_reg == in_ver_reg) &&
                    (stg_crc_reg == in_crc_reg) && (16'(stg_count_reg) == in_total_reg) &&
                    (stg_per_reg == in_per_reg);
        older     = stg_active_reg && !force_a && (in_ver_reg < stg_version_reg);

        chunk_ok  = stg_active_reg && (in_ver_reg == stg_version_reg) &&
                    (in_cnum_reg < 16'(stg_ctot_reg)) &&
                    (32'(in_cnum_reg) < RECORD_CAPACITY);
        remain    = (24'(stg_count_reg) > prod_reg) ? (24'(stg_count_reg) - prod_reg) : '0;
        expect_rec = (remain < 24'(stg_per_reg)) ? remain[7:0] : stg_per_reg;
        seen      = (ram_rd_data == epoch_reg);
        idle_inc  = (idle_reg == '1) ? idle_reg : idle_reg + 32'd1;

        stg_active_next  = stg_active_reg;
        stg_version_next = stg_version_reg;
        stg_crc_next     = stg_crc_reg;
        stg_count_next   = stg_count_reg;
        stg_per_next     = stg_per_reg;
        stg_ctot_next    = stg_ctot_reg;
        rcvd_next        = rcvd_reg;
        idle_next        = idle_reg;
        ann_mac_next     = ann_mac_reg;
        err_next         = err_reg;
        epoch_next       = epoch_reg;
        epoch_wrap       = 1'b0;
        dec_wr_en        = 1'b0;

        o_status    = ST_IGNORED;
        o_reply     = 1'b0;
        o_reply_mac = '0;
        o_wen       = 1'b0;
        o_woff      = '0;
        o_wcnt      = '0;
        o_done      = 1'b0;
        o_dver      = '0;
        o_dcrc      = '0;
        o_dcnt      = '0;

        case (in_kind_reg)
            KIND_ANNOUNCE: begin
                o_reply     = 1'b1;
                o_reply_mac = in_mac_reg;
                if (!valid_a) begin
                    err_next = ERR_INVALID;
                    o_status = ST_INVALID;
                end else if (same_inst) begin
                    o_status = ST_CURRENT;
                end else if (!newer) begin
                    o_status = ST_NOT_NEWER;
                end else if (same_stg) begin
                    idle_next    = '0;
                    ann_mac_next = in_mac_reg;
                    o_status     = ST_REFRESHED;
                end else if (older) begin
                    o_status = ST_NOT_NEWER;
                end else begin
                    // Start a fresh staging; a new epoch empties the seen map
                    stg_active_next  = 1'b1;
                    stg_version_next = in_ver_reg;
                    stg_crc_next     = in_crc_reg;
                    stg_count_next   = in_total_reg[10:0];
                    stg_per_next     = in_per_reg;
                    stg_ctot_next    = in_ctot_reg[10:0];
                    rcvd_next        = '0;
                    idle_next        = '0;
                    ann_mac_next     = in_mac_reg;
                    epoch_wrap       = (epoch_reg == EPOCH_LAST);
                    epoch_next       = epoch_wrap ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
                    o_status         = ST_STARTED;
                    if (in_total_reg == 16'd0) begin
                        o_status        = ST_COMPLETED;
                        o_done          = 1'b1;
                        o_dver          = in_ver_reg;
                        o_dcrc          = in_crc_reg;
                        stg_active_next = 1'b0;
                        ann_mac_next    = '0;
                    end
                end
            end
            KIND_CHUNK: begin
                if (chunk_ok && (in_crec_reg == expect_rec)) begin
                    idle_next = '0;
                    if (seen) begin
                        o_status = ST_DUPLICATE;
                    end else begin
                        dec_wr_en = 1'b1;
                        rcvd_next = rcvd_reg + 11'd1;
                        o_status  = ST_STORED;
                        o_wen     = 1'b1;
                        o_woff    = prod_reg[9:0];
                        o_wcnt    = in_crec_reg;
                        if (rcvd_next == stg_ctot_reg) begin
                            o_status        = ST_COMPLETED;
                            o_reply         = 1'b1;
                            o_reply_mac     = ann_mac_reg;
                            o_done          = 1'b1;
                            o_dver          = stg_version_reg;
                            o_dcrc          = stg_crc_reg;
                            o_dcnt          = stg_count_reg;
                            stg_active_next = 1'b0;
                            rcvd_next       = '0;
                            idle_next       = '0;
                            ann_mac_next    = '0;
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (stg_active_reg) begin
                    idle_next = idle_inc;
                    if (idle_inc > idle_timeout_reg) begin
                        stg_active_next = 1'b0;
                        rcvd_next       = '0;
                        idle_next       = '0;
                        ann_mac_next    = '0;
                        err_next        = ERR_TIMEOUT;
                        o_status        = ST_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
    end

    // Update staging state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_active_reg  <= 1'b0;
            stg_version_reg <= '0;
            stg_crc_reg     <= '0;
            stg_count_reg   <= '0;
            stg_per_reg     <= '0;
            stg_ctot_reg    <= '0;
            rcvd_reg        <= '0;
            idle_reg        <= '0;
            ann_mac_reg     <= '0;
            err_reg         <= ERR_OK;
            epoch_reg       <= EPOCH_FIRST;
        end else if (decide_go) begin
            stg_active_reg  <= stg_active_next;
            stg_version_reg <= stg_version_next;
            stg_crc_reg     <= stg_crc_next;
            stg_count_reg   <= stg_count_next;
            stg_per_reg     <= stg_per_next;
            stg_ctot_reg    <= stg_ctot_next;
            rcvd_reg        <= rcvd_next;
            idle_reg        <= idle_next;
            ann_mac_reg     <= ann_mac_next;
            err_reg         <= err_next;
            epoch_reg       <= epoch_next;
        end
    end

    // Result register: load on decide, drop on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (decide_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (decide_go) begin
            o_status_reg    <= o_status;
            o_reply_reg     <= o_reply;
            o_reply_mac_reg <= o_reply_mac;
            o_wen_reg       <= o_wen;
            o_woff_reg      <= o_woff;
            o_wcnt_reg      <= o_wcnt;
            o_done_reg      <= o_done;
            o_dver_reg      <= o_dver;
            o_dcrc_reg      <= o_dcrc;
            o_dcnt_reg      <= o_dcnt;
            o_rcvd_reg      <= rcvd_next;
            o_err_reg       <= err_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = o_status_reg;
    assign m_reply_needed    = o_reply_reg;
    assign m_reply_mac       = o_reply_mac_reg;
    assign m_write_enable    = o_wen_reg;
    assign m_write_offset    = o_woff_reg;
    assign m_write_count     = o_wcnt_reg;
    assign m_done_res        = o_done_reg;
    assign m_done_version    = o_dver_reg;
    assign m_done_crc        = o_dcrc_reg;
    assign m_done_count      = o_dcnt_reg;
    assign m_received_chunks = o_rcvd_reg;
    assign m_last_error      = o_err_reg;

endmodule

[rtl/core/cur_checker.sv]
// Port-level checks for chunked_update_reassembly, bound to the top level.
// Depends on cur_pkg for status codes.
module cur_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_status,
    input logic        m_reply_needed,
    input logic        m_done_res,
    input logic [10:0] m_received_chunks
);

    import cur_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result word changed while stalled");

    // One word in flight: no accept right after an accept
    a_seq_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // Completion clears the staging count and asks for a reply
    a_done_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_received_chunks == 11'd0 && m_reply_needed &&
        m_status == ST_COMPLETED)
        else $error("completion word inconsistent");

endmodule

bind chunked_update_reassembly cur_checker u_cur_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_reply_needed    (m_reply_needed),
    .m_done_res        (m_done_res),
    .m_received_chunks (m_received_chunks)
);

[test/tb.sv]
// Self-checking testbench for the chunked update reassembly tracker.
// Depends on cur_pkg and the chunked_update_reassembly top level.
`timescale 1ns / 100ps

module tb;
    import cur_pkg::*;

    localparam int unsigned CAP = 1024;
    localparam int unsigned MAXPC = 16;
    localparam int unsigned N_RANDOM = 1250;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] mac;
        logic        bcast;
        logic        force_bit;
        logic [31:0] ver;
        logic [31:0] crc;
        logic [15:0] total;
        logic [7:0]  per;
        logic [15:0] ctotal;
        logic [15:0] cnum;
        logic [7:0]  crec;
    } word_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        reply;
        logic [47:0] rmac;
        logic        wen;
        logic [9:0]  woff;
        logic [7:0]  wcnt;
        logic        done;
        logic [31:0] dver;
        logic [31:0] dcrc;
        logic [10:0] dcnt;
        logic [10:0] rxc;
        logic [1:0]  err;
    } result_t;

    // Directed row: word plus an optional typed-in expected status
    typedef struct {
        word_t      w;
        logic       has_st;
        logic [3:0] st;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    word_t sw = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    result_t mr;

    always #5 aclk = ~aclk;

    chunked_update_reassembly u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(sw.kind), .s_sender_mac(sw.mac), .s_is_broadcast(sw.bcast),
        .s_force_flag(sw.force_bit), .s_update_version(sw.ver), .s_update_crc(sw.crc),
        .s_record_total(sw.total), .s_records_each_chunk(sw.per),
        .s_chunk_total(sw.ctotal), .s_chunk_number(sw.cnum), .s_chunk_records(sw.crec),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(mr.status), .m_reply_needed(mr.reply), .m_reply_mac(mr.rmac),
        .m_write_enable(mr.wen), .m_write_offset(mr.woff), .m_write_count(mr.wcnt),
        .m_done_res(mr.done), .m_done_version(mr.dver), .m_done_crc(mr.dcrc),
        .m_done_count(mr.dcnt), .m_received_chunks(mr.rxc), .m_last_error(mr.err)
    );

    // Predictor copy of registers and tracker state
    logic [31:0] inst_ver, inst_crc, idle_lim;
    logic [10:0] inst_cnt, rec_cap;
    logic        stg_on;
    logic [31:0] stg_ver, stg_crc, idle_ms;
    logic [10:0] stg_cnt, stg_ctot, rx_chunks;
    logic [7:0]  stg_per;
    logic [47:0] stg_mac;
    logic        seen_map [CAP];
    logic [1:0]  err_code;

    result_t expected_q[$];
    logic    st_known_q[$];
    logic [3:0] st_typed_q[$];
    int fails = 0;
    int n_results = 0;
    int n_started = 0;
    int n_done = 0;
    int n_sent = 0;

    function automatic void drop_staging();
        stg_on = 1'b0; stg_ver = '0; stg_crc = '0; stg_cnt = '0; stg_per = '0;
        stg_ctot = '0; rx_chunks = '0; idle_ms = '0; stg_mac = '0;
        foreach (seen_map[i]) seen_map[i] = 1'b0;
    endfunction

    function automatic void cfg_model(logic [2:0] idx, logic [31:0] d);
        case (idx)
            CFG_INST_VERSION: inst_ver = d;
            CFG_INST_CRC:     inst_crc = d;
            CFG_INST_COUNT:   inst_cnt = d[10:0];
            CFG_REC_CAPACITY: rec_cap = d[10:0];
            CFG_IDLE_TIMEOUT: idle_lim = d;
            default: ;
        endcase
    endfunction

    function automatic void finish_staging(ref result_t r);
        r.status = ST_COMPLETED; r.reply = 1'b1; r.rmac = stg_mac;
        r.done = 1'b1; r.dver = stg_ver; r.dcrc = stg_crc; r.dcnt = stg_cnt;
        drop_staging();
    endfunction

    // Advance tracker state by one word and return the result it gives
    function automatic result_t track_update(word_t w);
        result_t r;
        logic forced, ok;
        int unsigned want, off, remain;
        r = '0;
        forced = w.force_bit && !w.bcast;
        case (w.kind)
            KIND_ANNOUNCE: begin
                want = (w.per != 0) ? (int'(w.total) + w.per - 1) / w.per : 0;
                ok = w.per >= 1 && w.per <= MAXPC && w.total <= rec_cap &&
                     w.total <= CAP && w.ctotal == want;
                r.reply = 1'b1; r.rmac = w.mac;
                if (!ok) begin
                    err_code = ERR_INVALID; r.status = ST_INVALID;
                end else if (w.ver == inst_ver && w.crc == inst_crc && w.total == inst_cnt) begin
                    r.status = ST_CURRENT;
                end else if (!(w.ver > inst_ver || forced)) begin
                    r.status = ST_NOT_NEWER;
                end else if (stg_on && stg_ver == w.ver && stg_crc == w.crc &&
                             stg_cnt == w.total && stg_per == w.per) begin
                    idle_ms = '0; stg_mac = w.mac; r.status = ST_REFRESHED;
                end else if (stg_on && !forced && w.ver < stg_ver) begin
                    r.status = ST_NOT_NEWER;
                end else begin
                    drop_staging();
                    stg_on = 1'b1; stg_ver = w.ver; stg_crc = w.crc; stg_cnt = w.total[10:0];
                    stg_per = w.per; stg_ctot = w.ctotal[10:0]; stg_mac = w.mac;
                    r.status = ST_STARTED;
                    if (w.total == 0) finish_staging(r);
                end
            end
            KIND_CHUNK: begin
                if (stg_on && w.ver == stg_ver && w.cnum < stg_ctot && w.cnum < CAP) begin
                    off = w.cnum * stg_per;
                    remain = (stg_cnt > off) ? stg_cnt - off : 0;
                    want = (remain < stg_per) ? remain : stg_per;
                    if (w.crec == want) begin
                        idle_ms = '0;
                        if (seen_map[w.cnum]) begin
                            r.status = ST_DUPLICATE;
                        end else begin
                            seen_map[w.cnum] = 1'b1;
                            rx_chunks = rx_chunks + 1'b1;
                            r.status = ST_STORED; r.wen = 1'b1;
                            r.woff = off[9:0]; r.wcnt = w.crec;
                            if (rx_chunks == stg_ctot) finish_staging(r);
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (stg_on) begin
                    if (idle_ms != 32'hFFFF_FFFF) idle_ms++;
                    if (idle_ms > idle_lim) begin
                        drop_staging(); err_code = ERR_TIMEOUT; r.status = ST_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
        r.rxc = rx_chunks;
        r.err = err_code;
        return r;
    endfunction

    // Drive one word; predict at acceptance; valid stays up when no gap is drawn
    task automatic send_word(word_t w, logic has_st, logic [3:0] st);
        int unsigned gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        sw <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(track_update(w));
        st_known_q.push_back(has_st);
        st_typed_q.push_back(st);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= d;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_model(idx, d);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Random receiver stall per result
    initial begin
        int unsigned gap;
        @(negedge aclk);
        forever begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_t e;
            logic known;
            logic [3:0] typed;
            n_results++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, mr);
                fails++;
            end else begin
                e = expected_q.pop_front();
                known = st_known_q.pop_front();
                typed = st_typed_q.pop_front();
                if (known && typed != mr.status) begin
                    $display("%0t: typed status expected %0d actual %0d",
                             $time, typed, mr.status);
                    fails++;
                end
                if (e !== mr) begin
                    $display("%0t: result expected %p actual %p", $time, e, mr);
                    fails++;
                end
                if (mr.status == ST_STARTED) n_started++;
                if (mr.done) n_done++;
            end
        end
    end

    function automatic word_t mk_announce(logic [31:0] v, logic [15:0] tot, logic [7:0] per,
                                          logic frc);
        word_t w;
        w = '0;
        w.kind = KIND_ANNOUNCE; w.mac = {$urandom, $urandom};
        w.ver = v; w.crc = $urandom; w.total = tot; w.per = per; w.force_bit = frc;
        w.ctotal = (per != 0) ? 16'((int'(tot) + per - 1) / per) : 16'd0;
        return w;
    endfunction

    function automatic word_t mk_chunk(logic [15:0] n);
        word_t w;
        int unsigned off, remain;
        w = '0;
        w.kind = KIND_CHUNK; w.mac = {$urandom, $urandom}; w.ver = stg_ver; w.cnum = n;
        off = n * stg_per;
        remain = (stg_cnt > off) ? stg_cnt - off : 0;
        w.crec = (remain < stg_per) ? 8'(remain) : stg_per;
        return w;
    endfunction

    function automatic word_t mk_tick();
        word_t w;
        w = '0;
        w.kind = KIND_TICK;
        return w;
    endfunction

    function automatic word_t mk_noise();
        word_t w;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(word_t)-1:0];
        if ($urandom_range(0, 3) != 0) w.kind = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) w.per = 8'($urandom_range(0, 17));
        if ($urandom_range(0, 1)) w.total = 16'($urandom_range(0, 1100));
        if ($urandom_range(0, 1) && w.per != 0)
            w.ctotal = 16'((int'(w.total) + w.per - 1) / w.per);
        return w;
    endfunction

    // Well-formed transfer with shuffled, duplicated and stray chunks, ticks and noise words
    task automatic run_transfer(int unsigned big);
        int unsigned tot, per, nch, idx;
        logic [15:0] order[$];
        tot = big ? $urandom_range(900, CAP) : $urandom_range(0, 60);
        if (tot > rec_cap) tot = rec_cap;
        per = big ? $urandom_range(8, MAXPC) : $urandom_range(1, MAXPC);
        send_word(mk_announce(inst_ver + $urandom_range(1, 50), 16'(tot), 8'(per),
                              $urandom_range(0, 5) == 0), 1'b0, '0);
        if (!stg_on) return;
        nch = stg_ctot;
        for (int i = 0; i < nch; i++) order.push_back(16'(i));
        order.shuffle();
        while (order.size() != 0 && stg_on) begin
            idx = $urandom_range(0, 9);
            if (idx == 0) send_word(mk_chunk(16'($urandom_range(0, nch))), 1'b0, '0);
            else if (idx == 1) send_word(mk_tick(), 1'b0, '0);
            else if (idx == 2) send_word(mk_noise(), 1'b0, '0);
            else send_word(mk_chunk(order.pop_front()), 1'b0, '0);
        end
    endtask

    row_t dir_rows[$];

    initial begin
        row_t rw;
        cfg_model(CFG_INST_VERSION, 0); cfg_model(CFG_INST_CRC, 0);
        cfg_model(CFG_INST_COUNT, 0); cfg_model(CFG_REC_CAPACITY, 1024);
        cfg_model(CFG_IDLE_TIMEOUT, 10000);
        err_code = ERR_OK;
        drop_staging();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table; chunks are built from the running prediction
        rw.has_st = 1'b1;
        rw.w = mk_tick(); rw.st = ST_IGNORED; dir_rows.push_back(rw);
        rw.w = mk_announce(0, 0, 0, 0); rw.st = ST_INVALID; dir_rows.push_back(rw);
        rw.w = mk_announce(5, 10, 17, 0); rw.st = ST_INVALID; dir_rows.push_back(rw);
        rw.w = mk_announce(5, 1025, 16, 0); rw.st = ST_INVALID; dir_rows.push_back(rw);
        rw.w = mk_announce(5, 10, 4, 0); rw.w.ctotal = 2; rw.st = ST_INVALID;
        dir_rows.push_back(rw);
        rw.w = mk_announce(0, 0, 1, 0); rw.w.crc = 0; rw.st = ST_CURRENT; dir_rows.push_back(rw);
        rw.w = mk_announce(0, 5, 1, 0); rw.st = ST_NOT_NEWER; dir_rows.push_back(rw);
        rw.w = mk_announce(7, 0, 16, 0); rw.st = ST_COMPLETED; dir_rows.push_back(rw);
        rw.w = mk_announce(32'hFFFF_FFFF, 1024, 16, 0); rw.w.mac = '1; rw.st = ST_STARTED;
        dir_rows.push_back(rw);
        rw.w.mac = '0; rw.st = ST_REFRESHED; dir_rows.push_back(rw);
        rw.w = mk_announce(9, 3, 1, 0); rw.w.bcast = 1; rw.w.force_bit = 1;
        rw.st = ST_NOT_NEWER; dir_rows.push_back(rw);
        rw.w = '1; rw.w.kind = 2'd3; rw.st = ST_IGNORED; dir_rows.push_back(rw);
        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].has_st, dir_rows[i].st);
        // Chunks into the big staging: first, duplicate, last, mismatches
        send_word(mk_chunk(0), 1'b1, ST_STORED);
        send_word(mk_chunk(0), 1'b1, ST_DUPLICATE);
        send_word(mk_chunk(63), 1'b1, ST_STORED);
        rw.w = mk_chunk(64); send_word(rw.w, 1'b1, ST_IGNORED);
        rw.w = mk_chunk(1); rw.w.crec = 15; send_word(rw.w, 1'b1, ST_IGNORED);
        rw.w = mk_chunk(1); rw.w.ver = 3; send_word(rw.w, 1'b1, ST_IGNORED);
        // Forced older announce preempts
        send_word(mk_announce(2, 3, 2, 1), 1'b1, ST_STARTED);
        send_word(mk_chunk(0), 1'b0, '0);
        send_word(mk_chunk(1), 1'b1, ST_COMPLETED);
        wait_drained();

        // Short timeout, then walk to a timeout
        write_reg(CFG_IDLE_TIMEOUT, 1);
        send_word(mk_announce(100, 5, 5, 0), 1'b1, ST_STARTED);
        send_word(mk_tick(), 1'b1, ST_IGNORED);
        send_word(mk_tick(), 1'b1, ST_TIMEOUT);
        wait_drained();

        // Random phases across register settings
        for (int ph = 0; n_sent < N_RANDOM; ph++) begin
            write_reg(CFG_INST_VERSION, (ph % 4 == 3) ? 32'hFFFF_FFF0 : $urandom_range(0, 1000));
            write_reg(CFG_INST_CRC, (ph % 3 == 0) ? 32'hFFFF_FFFF : $urandom);
            write_reg(CFG_INST_COUNT, (ph % 5 == 4) ? 1024 : $urandom_range(0, 40));
            write_reg(CFG_REC_CAPACITY, (ph % 4 == 0) ? 1024 :
                      (ph % 4 == 1) ? 0 : $urandom_range(20, 2047));
            write_reg(CFG_IDLE_TIMEOUT, (ph % 3 == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 6));
            for (int k = 0; k < 12 && n_sent < N_RANDOM; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_word(mk_noise(), 1'b0, '0);
                end else begin
                    run_transfer(ph % 8 == 7 && k == 0);
                end
            end
            wait_drained();
        end

        $display("Ran directed cases and %0d results over several register settings;", n_results);
        $display("%0d stagings started, %0d completed.", n_started, n_done);
        if (fails == 0) begin
            $display("chunked_update_reassembly: match");
        end else begin
            $display("chunked_update_reassembly: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #50ms;
        $display("chunked_update_reassembly: mismatch");
        $finish;
    end

endmodule

[chunked_update_reassembly.f]
rtl/core/cur_pkg.sv
rtl/core/cur_ram.sv
rtl/core/chunked_update_reassembly.sv
rtl/core/cur_checker.sv
test/tb.sv
